FILE: rtl/ple_pkg.sv
// ple_pkg: shared constants, transfer payload types and circular-slot helpers
// for the positional list engine. No dependencies.
package ple_pkg;

    localparam int CAPACITY = 256;
    localparam int ELEM_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 9;
    localparam int ST_W     = 2;
    localparam int COUNT_W  = 9;

    localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_REAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_AT    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         position;
        logic signed [ELEM_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [ELEM_W-1:0] removed_value;
        logic [ST_W-1:0]          status;
        logic [COUNT_W-1:0]       element_count;
    } t_out_item;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
        return (p == '0) ? ADDR_W'(CAPACITY - 1) : p - 1'b1;
    endfunction

    // physical slot of logical element k
    function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] head,
                                               input logic [CNT_W-1:0]  k);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(k);
        if (sum >= (CNT_W + 1)'(CAPACITY)) begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/positional_list_engine_core.sv
// positional_list_engine_core: ordered list held in a circular element RAM.
// Depends on ple_pkg and ple_ram.
//
// One request at a time; every request gives one result. Adds at either end,
// errors and unused op codes finish straight from idle; removals at the front
// or rear wait for the registered RAM read. Insert inside the list and remove at
// 1-based position p (p>1) move the elements behind p by one slot, each read
// from the RAM and written back one slot over. The result sits in an output
// register, so a stalled result holds the engine for at most one more request.
// No clearing pass is needed after reset.
module positional_list_engine_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ple_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ple_pkg::t_out_item o_out_item
);

    localparam int AW   = ple_pkg::ADDR_W;
    localparam int CW   = ple_pkg::CNT_W;
    localparam int EW   = ple_pkg::ELEM_W;
    localparam int PW   = ple_pkg::POS_W;
    localparam int KW   = ple_pkg::COUNT_W;
    localparam int CMPW = ((CW > PW) ? CW : PW) + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_FIN  = 5'b00100,
        S_DEL  = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [CW-1:0]      r_steps, n_steps;
    logic [AW-1:0]      r_ins_ptr, n_ins_ptr;
    logic [EW-1:0]      r_val, n_val;
    logic [EW-1:0]      r_rem, n_rem;
    logic               r_first, n_first;
    ple_pkg::t_out_item r_res, n_res;
    ple_pkg::t_out_item r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [EW-1:0]      ram_wdata, ram_rdata;

    logic               fin, out_free, in_xfer;
    ple_pkg::t_out_item fin_res;
    logic               go_front, go_rear, go_ins, go_del;
    logic [CW-1:0]      k, del_k;
    logic [CMPW-1:0]    pos_c, cnt_c;
    logic               full, empty;
    logic [ple_pkg::ST_W-1:0] st;

    ple_ram #(
        .WIDTH (EW),
        .DEPTH (ple_pkg::CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign pos_c    = CMPW'(i_in_item.position);
    assign cnt_c    = CMPW'(r_count);
    assign full     = (r_count == CW'(ple_pkg::CAPACITY));
    assign empty    = (r_count == '0);
    assign k        = CW'(pos_c - CMPW'(1));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_steps     = r_steps;
        n_ins_ptr   = r_ins_ptr;
        n_val       = r_val;
        n_rem       = r_rem;
        n_first     = r_first;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        fin         = 1'b0;
        fin_res     = '0;
        go_front    = 1'b0;
        go_rear     = 1'b0;
        go_ins      = 1'b0;
        go_del      = 1'b0;
        del_k       = '0;
        st          = ple_pkg::ST_OK;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_item.op)
                        ple_pkg::OP_ADD_FRONT: begin
                            if (full) st = ple_pkg::ST_FULL;
                            else go_front = 1'b1;
                        end
                        ple_pkg::OP_ADD_REAR: begin
                            if (full) st = ple_pkg::ST_FULL;
                            else go_rear = 1'b1;
                        end
                        ple_pkg::OP_REM_FRONT: begin
                            if (empty) st = ple_pkg::ST_UNDERFLOW;
                            else go_del = 1'b1;
                        end
                        ple_pkg::OP_REM_REAR: begin
                            if (empty) begin
                                st = ple_pkg::ST_UNDERFLOW;
                            end else begin
                                go_del = 1'b1;
                                del_k  = r_count - 1'b1;
                            end
                        end
                        ple_pkg::OP_INS_AT: begin
                            if (empty) begin
                                st = ple_pkg::ST_UNDERFLOW;
                            end else if (pos_c == '0 || pos_c > cnt_c + CMPW'(1)) begin
                                st = ple_pkg::ST_RANGE;
                            end else if (full) begin
                                st = ple_pkg::ST_FULL;
                            end else if (k == '0) begin
                                go_front = 1'b1;
                            end else if (k == r_count) begin
                                go_rear = 1'b1;
                            end else begin
                                go_ins = 1'b1;
                            end
                        end
                        ple_pkg::OP_REM_AT: begin
                            if (pos_c == '0 || pos_c > cnt_c) begin
                                st = ple_pkg::ST_RANGE;
                            end else begin
                                go_del = 1'b1;
                                del_k  = k;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (go_front) begin
                        n_head    = ple_pkg::ptr_dec(r_head);
                        ram_we    = 1'b1;
                        ram_waddr = ple_pkg::ptr_dec(r_head);
                        ram_wdata = i_in_item.value;
                        n_count   = r_count + 1'b1;
                        fin       = 1'b1;
                    end else if (go_rear) begin
                        ram_we    = 1'b1;
                        ram_waddr = ple_pkg::slot(r_head, r_count);
                        ram_wdata = i_in_item.value;
                        n_count   = r_count + 1'b1;
                        fin       = 1'b1;
                    end else if (go_ins) begin
                        ram_re    = 1'b1;
                        ram_raddr = ple_pkg::slot(r_head, r_count - 1'b1);
                        n_ptr     = ple_pkg::slot(r_head, r_count - 1'b1);
                        n_steps   = r_count - k;
                        n_ins_ptr = ple_pkg::slot(r_head, k);
                        n_val     = i_in_item.value;
                        n_count   = r_count + 1'b1;
                        n_state   = S_INS;
                    end else if (go_del) begin
                        ram_re    = 1'b1;
                        ram_raddr = ple_pkg::slot(r_head, del_k);
                        n_ptr     = ple_pkg::slot(r_head, del_k);
                        n_steps   = (del_k == '0) ? '0 : r_count - 1'b1 - del_k;
                        n_first   = 1'b1;
                        n_count   = r_count - 1'b1;
                        if (del_k == '0) begin
                            n_head = ple_pkg::ptr_inc(r_head);
                        end
                        n_state   = S_DEL;
                    end else begin
                        fin = 1'b1;
                    end
                    fin_res.status        = st;
                    fin_res.element_count = KW'(n_count);
                end
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = ple_pkg::ptr_inc(r_ptr);
                ram_wdata = ram_rdata;
                if (r_steps > CW'(1)) begin
                    ram_re    = 1'b1;
                    ram_raddr = ple_pkg::ptr_dec(r_ptr);
                    n_ptr     = ple_pkg::ptr_dec(r_ptr);
                    n_steps   = r_steps - 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                ram_we                = 1'b1;
                ram_waddr             = r_ins_ptr;
                ram_wdata             = r_val;
                fin                   = 1'b1;
                fin_res.status        = ple_pkg::ST_OK;
                fin_res.element_count = KW'(r_count);
            end
            S_DEL: begin
                n_first = 1'b0;
                if (r_first) begin
                    n_rem = ram_rdata;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = ple_pkg::ptr_dec(r_ptr);
                    ram_wdata = ram_rdata;
                end
                if (r_steps != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = ple_pkg::ptr_inc(r_ptr);
                    n_ptr     = ple_pkg::ptr_inc(r_ptr);
                    n_steps   = r_steps - 1'b1;
                end else begin
                    fin                   = 1'b1;
                    fin_res.removed_value = r_first ? ram_rdata : r_rem;
                    fin_res.status        = ple_pkg::ST_OK;
                    fin_res.element_count = KW'(r_count);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_out       = fin_res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_res   = fin_res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_steps   <= n_steps;
        r_ins_ptr <= n_ins_ptr;
        r_val     <= n_val;
        r_rem     <= n_rem;
        r_first   <= n_first;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ple_pkg::CAPACITY))
        else $error("element count above capacity");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && r_out_valid && i_out_stall) |=> (r_state == S_HOLD))
        else $error("finished result not parked while output stalled");

    a_ins_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_steps != '0))
        else $error("shift loop entered with no moves left");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !full && (i_in_item.op == ple_pkg::OP_ADD_FRONT ||
                              i_in_item.op == ple_pkg::OP_ADD_REAR))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("end add did not grow the list");

endmodule

FILE: rtl/ple_ram.sv
// ple_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for positional_list_engine_core: random and directed list
// requests over a valid/stall channel, checked against a queue-based list model.
// Depends on ple_pkg and the engine RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ple_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [ple_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam int ITEM_TARGET = 1750;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 300;

    typedef enum {MIX_BALANCED, MIX_GROW, MIX_SHRINK, MIX_FILL, MIX_DRAIN} t_mix;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    ple_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    ple_pkg::t_out_item o_out_item;

    ple_pkg::t_in_item                 request_backlog[$];
    ple_pkg::t_out_item                due_results[$];
    logic signed [ple_pkg::ELEM_W-1:0] model_list[$];
    int  gen_count = 0;
    int  queued = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    logic quiet;

    positional_list_engine_core u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    assign quiet = (cycle_count >= 2000) && (cycle_count < 6000);

    // list model: updates the held elements and returns the response
    function automatic ple_pkg::t_out_item apply_request(input ple_pkg::t_in_item req);
        ple_pkg::t_out_item resp;
        int n;
        int p;
        resp = '0;
        n = model_list.size();
        p = int'(req.position);
        case (req.op)
            ple_pkg::OP_ADD_FRONT: begin
                if (n >= ple_pkg::CAPACITY) resp.status = ple_pkg::ST_FULL;
                else model_list.push_front(req.value);
            end
            ple_pkg::OP_ADD_REAR: begin
                if (n >= ple_pkg::CAPACITY) resp.status = ple_pkg::ST_FULL;
                else model_list.push_back(req.value);
            end
            ple_pkg::OP_REM_FRONT: begin
                if (n == 0) resp.status = ple_pkg::ST_UNDERFLOW;
                else resp.removed_value = model_list.pop_front();
            end
            ple_pkg::OP_REM_REAR: begin
                if (n == 0) resp.status = ple_pkg::ST_UNDERFLOW;
                else resp.removed_value = model_list.pop_back();
            end
            ple_pkg::OP_INS_AT: begin
                if (n == 0) resp.status = ple_pkg::ST_UNDERFLOW;
                else if (p == 0 || p > n + 1) resp.status = ple_pkg::ST_RANGE;
                else if (n >= ple_pkg::CAPACITY) resp.status = ple_pkg::ST_FULL;
                else model_list.insert(p - 1, req.value);
            end
            ple_pkg::OP_REM_AT: begin
                if (p == 0 || p > n) begin
                    resp.status = ple_pkg::ST_RANGE;
                end else begin
                    resp.removed_value = model_list[p - 1];
                    model_list.delete(p - 1);
                end
            end
            default: ;
        endcase
        resp.element_count = ple_pkg::COUNT_W'(model_list.size());
        return resp;
    endfunction

    // queue a request; gen_count tracks the list length the engine will have
    task automatic queue_request(input logic [ple_pkg::OP_W-1:0] op, input int pos,
                                 input logic [ple_pkg::ELEM_W-1:0] val);
        ple_pkg::t_in_item req;
        req.op = op;
        req.position = pos[ple_pkg::POS_W-1:0];
        req.value = val;
        request_backlog.push_back(req);
        queued++;
        case (op)
            ple_pkg::OP_ADD_FRONT, ple_pkg::OP_ADD_REAR:
                if (gen_count < ple_pkg::CAPACITY) gen_count++;
            ple_pkg::OP_REM_FRONT, ple_pkg::OP_REM_REAR:
                if (gen_count > 0) gen_count--;
            ple_pkg::OP_INS_AT: begin
                if (gen_count > 0 && pos >= 1 && pos <= gen_count + 1 &&
                    gen_count < ple_pkg::CAPACITY)
                    gen_count++;
            end
            ple_pkg::OP_REM_AT: if (pos >= 1 && pos <= gen_count) gen_count--;
            default: ;
        endcase
    endtask

    function automatic int pick_pos(input int limit);
        int span;
        if (limit <= 0) return 1;
        if ($urandom_range(0, 1) == 0) begin
            span = (limit - 1 < 7) ? limit - 1 : 7;
            return limit - $urandom_range(0, span);
        end
        return $urandom_range(1, limit);
    endfunction

    function automatic logic [ple_pkg::ELEM_W-1:0] pick_value();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    task automatic random_request(input t_mix mix);
        int add_pct;
        int limit;
        case (mix)
            MIX_GROW:  add_pct = 75;
            MIX_SHRINK: add_pct = 25;
            MIX_FILL:  add_pct = 100;
            MIX_DRAIN: add_pct = 0;
            default:   add_pct = 50;
        endcase
        if ($urandom_range(0, 99) < 6) begin
            case ($urandom_range(0, 3))
                0: queue_request($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                                 $urandom_range(0, 511), $urandom());
                1: queue_request($urandom_range(0, 1) ? ple_pkg::OP_INS_AT : ple_pkg::OP_REM_AT,
                                 0, pick_value());
                2: begin
                    limit = gen_count + 2;
                    queue_request(ple_pkg::OP_INS_AT, $urandom_range(limit, 511), pick_value());
                end
                default: begin
                    limit = gen_count + 1;
                    queue_request(ple_pkg::OP_REM_AT, $urandom_range(limit, 511), pick_value());
                end
            endcase
        end else if ($urandom_range(0, 99) < add_pct) begin
            case ($urandom_range(0, 2))
                0: queue_request(ple_pkg::OP_ADD_FRONT, $urandom_range(0, 511), pick_value());
                1: queue_request(ple_pkg::OP_ADD_REAR, $urandom_range(0, 511), pick_value());
                default: queue_request(ple_pkg::OP_INS_AT, pick_pos(gen_count + 1),
                                       pick_value());
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0: queue_request(ple_pkg::OP_REM_FRONT, $urandom_range(0, 511), $urandom());
                1: queue_request(ple_pkg::OP_REM_REAR, $urandom_range(0, 511), $urandom());
                default: queue_request(ple_pkg::OP_REM_AT, pick_pos(gen_count), $urandom());
            endcase
        end
    endtask

    // sampled at the falling edge so the driver and monitor have settled
    task automatic wait_drained();
        while (request_backlog.size() != 0 || i_in_valid || due_results.size() != 0)
            @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                due_results.push_back(apply_request(i_in_item));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (request_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 30)) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= request_backlog.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        ple_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result transfer: %p", o_out_item);
                    error_count++;
                end else begin
                    want = due_results.pop_front();
                    if (o_out_item.removed_value !== want.removed_value) begin
                        $error("removed_value: expected %0d, got %0d",
                               want.removed_value, o_out_item.removed_value);
                        error_count++;
                    end
                    if (o_out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                        error_count++;
                    end
                    if (o_out_item.element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, o_out_item.element_count);
                        error_count++;
                    end
                end
            end
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 30);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        int phase_len;
        bit filled;
        filled = 1'b0;

        // empty list corner cases
        queue_request(ple_pkg::OP_REM_FRONT, 0, 32'h0);
        queue_request(ple_pkg::OP_REM_REAR, 511, 32'hFFFF_FFFF);
        queue_request(ple_pkg::OP_INS_AT, 1, 32'h1111_1111);
        queue_request(ple_pkg::OP_REM_AT, 0, 32'h0);
        queue_request(ple_pkg::OP_REM_AT, 1, 32'h0);
        queue_request(OP_SPARE_A, 511, 32'h7FFF_FFFF);
        queue_request(OP_SPARE_B, 0, 32'h8000_0000);
        // ends
        queue_request(ple_pkg::OP_ADD_FRONT, 0, 32'h7FFF_FFFF);
        queue_request(ple_pkg::OP_ADD_REAR, 511, 32'h8000_0000);
        queue_request(ple_pkg::OP_ADD_FRONT, 0, 32'hFFFF_FFFF);
        queue_request(ple_pkg::OP_ADD_REAR, 0, 32'h0);
        // positional inserts, list holds 4
        queue_request(ple_pkg::OP_INS_AT, 0, 32'h0);
        queue_request(ple_pkg::OP_INS_AT, 6, 32'h0);
        queue_request(ple_pkg::OP_INS_AT, 1, 32'h5555_5555);
        queue_request(ple_pkg::OP_INS_AT, 6, 32'hAAAA_AAAA);
        queue_request(ple_pkg::OP_INS_AT, 3, 32'h1234_5678);
        // positional removes, list holds 7
        queue_request(ple_pkg::OP_REM_AT, 0, 32'h0);
        queue_request(ple_pkg::OP_REM_AT, 8, 32'h0);
        queue_request(ple_pkg::OP_REM_AT, 511, 32'h0);
        queue_request(ple_pkg::OP_REM_AT, 1, 32'h0);
        queue_request(ple_pkg::OP_REM_AT, 6, 32'h0);
        queue_request(ple_pkg::OP_REM_AT, 3, 32'h0);
        queue_request(ple_pkg::OP_REM_FRONT, 0, 32'h0);
        queue_request(ple_pkg::OP_REM_REAR, 0, 32'h0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hold off until the directed requests have all completed
        wait_drained();

        while (queued < ITEM_TARGET) begin
            if (!filled && queued > 600) begin
                while (gen_count < ple_pkg::CAPACITY) random_request(MIX_FILL);
                repeat (20) random_request(MIX_GROW);
                while (gen_count > 0) random_request(MIX_DRAIN);
                filled = 1'b1;
                wait_drained();
            end
            phase_len = $urandom_range(30, 120);
            case ($urandom_range(0, 2))
                0: repeat (phase_len) random_request(MIX_BALANCED);
                1: repeat (phase_len) random_request(MIX_GROW);
                default: repeat (phase_len) random_request(MIX_SHRINK);
            endcase
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: positional_list_engine_core.f
rtl/ple_pkg.sv
rtl/ple_ram.sv
rtl/positional_list_engine_core.sv
bench/testbench.sv
